FILE: hw/rtl/i2cee_pkg.sv
// ----------------------------------------------------------------------------
// i2cee_pkg
// Shared types, codes and helper functions of the 24Cxx EEPROM sequencer.
// ----------------------------------------------------------------------------
package i2cee_pkg;

    localparam logic [7:0] POLL_LIMIT = 8'd255;
    localparam logic [3:0] DEV_ID     = 4'b1010;
    localparam logic [2:0] PAGE_LOG2_MAX = 3'd6;

    // part_type codes
    localparam logic [2:0] EE_24C01 = 3'd0;
    localparam logic [2:0] EE_24C04 = 3'd1;
    localparam logic [2:0] EE_24C08 = 3'd2;
    localparam logic [2:0] EE_24C16 = 3'd3;
    localparam logic [2:0] EE_24C32 = 3'd4;

    // configuration register indexes
    localparam logic [1:0] CFG_PART_TYPE = 2'd0;
    localparam logic [1:0] CFG_CHIP_PINS = 2'd1;
    localparam logic [1:0] CFG_PAGE_LOG2 = 2'd2;

    typedef enum logic [1:0] {
        REQ_BEGIN_WR = 2'd0,
        REQ_BEGIN_RD = 2'd1,
        REQ_RESPONSE = 2'd2,
        REQ_WR_DATA  = 2'd3
    } req_t;

    typedef enum logic [2:0] {
        OP_START     = 3'd0,
        OP_STOP      = 3'd1,
        OP_WRITE     = 3'd2,
        OP_READ_ACK  = 3'd3,
        OP_READ_NACK = 3'd4,
        OP_REQ       = 3'd5,
        OP_DONE      = 3'd6
    } op_t;

    typedef enum logic [1:0] {
        ST_OK      = 2'd0,
        ST_NACK    = 2'd1,
        ST_TIMEOUT = 2'd2
    } status_t;

    typedef enum logic [3:0] {
        PH_IDLE, PH_START, PH_DEV, PH_ADDR, PH_DREQ, PH_WDATA, PH_WSTOP,
        PH_PSTART, PH_PDEV, PH_RSTART, PH_RDEV, PH_RDATA,
        PH_FIN_OK, PH_FIN_NACK, PH_FIN_TO
    } phase_t;

    typedef struct packed {
        logic [2:0] part_type;
        logic [2:0] chip_pins;
        logic [2:0] page_size_log2;
    } cfg_t;

    typedef struct packed {
        req_t        req_type;
        logic [15:0] mem_addr;
        logic [15:0] length;
        logic [7:0]  wr_data;
        logic        ack;
        logic [7:0]  rx_byte;
    } item_t;

    typedef struct packed {
        op_t         bus_op;
        logic [7:0]  bus_byte;
        logic        read_valid;
        logic [7:0]  read_data;
        status_t     status;
        logic [15:0] bytes_read;
    } result_t;

    // device select byte: fixed id, then pins and high address bits at 3..1
    function automatic logic [7:0] dev_byte_for(input cfg_t cfg, input logic [15:0] addr);
        logic [2:0] sel;
        unique case (cfg.part_type)
            EE_24C01: sel = cfg.chip_pins;
            EE_24C04: sel = {cfg.chip_pins[2:1], addr[8]};
            EE_24C08: sel = {cfg.chip_pins[2], addr[9:8]};
            EE_24C16: sel = addr[10:8];
            default:  sel = cfg.chip_pins;
        endcase
        return {DEV_ID, sel, 1'b0};
    endfunction

    // bytes up to the end of the page, limited by what is left
    function automatic logic [6:0] chunk_len(input logic [2:0] psl,
                                             input logic [15:0] addr,
                                             input logic [15:0] left);
        logic [2:0] lg;
        logic [6:0] page;
        logic [6:0] n;
        lg   = (psl > PAGE_LOG2_MAX) ? PAGE_LOG2_MAX : psl;
        page = 7'd1 << lg;
        n    = page - (addr[6:0] & (page - 7'd1));
        if ({9'd0, n} > left) begin
            n = left[6:0];
        end
        return n;
    endfunction

endpackage

FILE: hw/rtl/i2c_eeprom_access_sequencer.sv
// ----------------------------------------------------------------------------
// i2c_eeprom_access_sequencer
// 24Cxx EEPROM transfer sequencer driving a byte-level I2C engine.
// ----------------------------------------------------------------------------
//  channel  | dir | tuser          | tdata (low bit up)
//  s_       | in  | req_type[1:0]  | mem_addr, length, wr_data, ack, rx_byte
//  m_       | out | bus_op[2:0]    | bus_byte, read_valid, read_data, status,
//           |     |                | bytes_read
//  cfg_     | in  | -              | index 0 part_type, 1 chip_pins, 2 page log2
//
// One word per cycle while m_ is not stalled: a word is registered, then the
// state machine turns it into at most one command, registered in the output
// register that drives m_tvalid. A stalled m_ side holds the input register;
// s_tready falls only while both registers are full and m_tready is low.
// Reset is synchronous; no clearing pass, the block is ready right after it.
// ----------------------------------------------------------------------------
module i2c_eeprom_access_sequencer (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [55:0] s_tdata,   // mem_addr, length, wr_data, ack, rx_byte, zero pad
    input  logic [1:0]  s_tuser,   // req_type
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [39:0] m_tdata,   // bus_byte, read_valid, read_data, status, bytes_read, pad
    output logic [2:0]  m_tuser,   // bus_op
    input  logic        cfg_we,
    input  logic [1:0]  cfg_index,
    input  logic [2:0]  cfg_wdata
);
    import i2cee_pkg::*;

    logic    in_valid_reg;
    item_t   in_item_reg;
    item_t   in_item;
    logic    m_valid_reg;
    result_t m_result_reg;
    cfg_t    cfg_reg;
    logic    advance;
    logic    step_res_valid;
    result_t step_res;

    assign in_item.req_type = req_t'(s_tuser);
    assign in_item.mem_addr = s_tdata[15:0];
    assign in_item.length   = s_tdata[31:16];
    assign in_item.wr_data  = s_tdata[39:32];
    assign in_item.ack      = s_tdata[40];
    assign in_item.rx_byte  = s_tdata[48:41];

    assign advance  = in_valid_reg && (!m_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg <= '{part_type: EE_24C01, chip_pins: 3'd0, page_size_log2: 3'd3};
        end else if (cfg_we) begin
            unique case (cfg_index)
                CFG_PART_TYPE: cfg_reg.part_type      <= cfg_wdata;
                CFG_CHIP_PINS: cfg_reg.chip_pins      <= cfg_wdata;
                CFG_PAGE_LOG2: cfg_reg.page_size_log2 <= cfg_wdata;
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tready) begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tready && s_tvalid) begin
            in_item_reg <= in_item;
        end
    end

    i2cee_seq u_seq (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .step_valid (advance),
        .item       (in_item_reg),
        .cfg        (cfg_reg),
        .res_valid  (step_res_valid),
        .res        (step_res)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (advance && step_res_valid) begin
            m_valid_reg <= 1'b1;
        end else if (m_tready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance && step_res_valid) begin
            m_result_reg <= step_res;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tuser  = m_result_reg.bus_op;
    assign m_tdata  = {5'd0, m_result_reg.bytes_read, m_result_reg.status,
                       m_result_reg.read_data, m_result_reg.read_valid,
                       m_result_reg.bus_byte};

    // a produced command always lands in the output register
    a_res_lands: assert property (@(posedge aclk) disable iff (!aresetn)
        (advance && step_res_valid) |=> m_valid_reg)
        else $error("command lost");

    // a held word is never overwritten while it waits
    a_hold_word: assert property (@(posedge aclk) disable iff (!aresetn)
        (in_valid_reg && !advance) |=> (in_valid_reg && $stable(in_item_reg)))
        else $error("waiting word replaced");

    // an undelivered command is never replaced
    a_no_overrun: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && !m_tready) |-> !advance)
        else $error("output register overrun");

endmodule

FILE: hw/rtl/i2cee_seq.sv
// ----------------------------------------------------------------------------
// i2cee_seq
// Transfer state machine: takes one word per strobe and gives at most one
// bus command in the same cycle.
// ----------------------------------------------------------------------------
module i2cee_seq (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              step_valid,
    input  i2cee_pkg::item_t  item,
    input  i2cee_pkg::cfg_t   cfg,
    output logic              res_valid,
    output i2cee_pkg::result_t res
);
    import i2cee_pkg::*;

    phase_t      phase_reg, phase_next;
    logic [15:0] cur_addr_reg, cur_addr_next;
    logic [15:0] bytes_left_reg, bytes_left_next;
    logic [6:0]  chunk_left_reg, chunk_left_next;
    logic        addr_lo_pend_reg, addr_lo_pend_next;
    logic [7:0]  poll_left_reg, poll_left_next;
    logic [7:0]  device_byte_reg, device_byte_next;
    logic [15:0] read_count_reg, read_count_next;
    logic        is_read_reg, is_read_next;

    logic [15:0] left_dec;
    logic [15:0] count_inc;
    logic [6:0]  chunk_dec;
    logic [7:0]  poll_dec;
    logic        two_addr;

    assign left_dec  = bytes_left_reg - 16'd1;
    assign count_inc = read_count_reg + 16'd1;
    assign chunk_dec = chunk_left_reg - 7'd1;
    assign poll_dec  = poll_left_reg - 8'd1;
    assign two_addr  = (cfg.part_type >= EE_24C32);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg        <= PH_IDLE;
            cur_addr_reg     <= '0;
            bytes_left_reg   <= '0;
            chunk_left_reg   <= '0;
            addr_lo_pend_reg <= 1'b0;
            poll_left_reg    <= POLL_LIMIT;
            device_byte_reg  <= {DEV_ID, 4'd0};
            read_count_reg   <= '0;
            is_read_reg      <= 1'b0;
        end else if (step_valid) begin
            phase_reg        <= phase_next;
            cur_addr_reg     <= cur_addr_next;
            bytes_left_reg   <= bytes_left_next;
            chunk_left_reg   <= chunk_left_next;
            addr_lo_pend_reg <= addr_lo_pend_next;
            poll_left_reg    <= poll_left_next;
            device_byte_reg  <= device_byte_next;
            read_count_reg   <= read_count_next;
            is_read_reg      <= is_read_next;
        end
    end

    always_comb begin
        logic nack_abort;
        phase_next        = phase_reg;
        cur_addr_next     = cur_addr_reg;
        bytes_left_next   = bytes_left_reg;
        chunk_left_next   = chunk_left_reg;
        addr_lo_pend_next = addr_lo_pend_reg;
        poll_left_next    = poll_left_reg;
        device_byte_next  = device_byte_reg;
        read_count_next   = read_count_reg;
        is_read_next      = is_read_reg;
        res_valid         = 1'b0;
        res               = '0;
        nack_abort        = 1'b0;

        unique case (item.req_type)
            REQ_BEGIN_WR, REQ_BEGIN_RD: begin
                if (phase_reg == PH_IDLE) begin
                    is_read_next      = (item.req_type == REQ_BEGIN_RD);
                    cur_addr_next     = item.mem_addr;
                    bytes_left_next   = item.length;
                    read_count_next   = '0;
                    chunk_left_next   = '0;
                    addr_lo_pend_next = 1'b0;
                    res_valid         = 1'b1;
                    if (item.length == 16'd0) begin
                        res.bus_op = OP_DONE;
                        res.status = ST_OK;
                        phase_next = PH_IDLE;
                    end else begin
                        device_byte_next = dev_byte_for(cfg, item.mem_addr);
                        phase_next       = PH_START;
                        res.bus_op       = OP_START;
                        if (item.req_type == REQ_BEGIN_WR) begin
                            chunk_left_next = chunk_len(cfg.page_size_log2, item.mem_addr,
                                                        item.length);
                        end
                    end
                end
            end
            REQ_WR_DATA: begin
                if (phase_reg == PH_DREQ) begin
                    phase_next   = PH_WDATA;
                    res_valid    = 1'b1;
                    res.bus_op   = OP_WRITE;
                    res.bus_byte = item.wr_data;
                end
            end
            REQ_RESPONSE: begin
                unique case (phase_reg)
                    PH_START: begin
                        phase_next   = PH_DEV;
                        res_valid    = 1'b1;
                        res.bus_op   = OP_WRITE;
                        res.bus_byte = device_byte_reg;
                    end
                    PH_DEV: begin
                        if (!item.ack) begin
                            nack_abort = 1'b1;
                        end else begin
                            phase_next        = PH_ADDR;
                            addr_lo_pend_next = two_addr;
                            res_valid         = 1'b1;
                            res.bus_op        = OP_WRITE;
                            res.bus_byte      = two_addr ? cur_addr_reg[15:8]
                                                         : cur_addr_reg[7:0];
                        end
                    end
                    PH_ADDR: begin
                        if (!item.ack) begin
                            nack_abort = 1'b1;
                        end else begin
                            res_valid = 1'b1;
                            if (addr_lo_pend_reg) begin
                                addr_lo_pend_next = 1'b0;
                                res.bus_op        = OP_WRITE;
                                res.bus_byte      = cur_addr_reg[7:0];
                            end else if (is_read_reg) begin
                                phase_next = PH_RSTART;
                                res.bus_op = OP_START;
                            end else begin
                                phase_next = PH_DREQ;
                                res.bus_op = OP_REQ;
                            end
                        end
                    end
                    PH_WDATA: begin
                        if (!item.ack) begin
                            nack_abort = 1'b1;
                        end else begin
                            chunk_left_next = chunk_dec;
                            bytes_left_next = left_dec;
                            cur_addr_next   = cur_addr_reg + 16'd1;
                            res_valid       = 1'b1;
                            if (chunk_dec != 7'd0) begin
                                phase_next = PH_DREQ;
                                res.bus_op = OP_REQ;
                            end else begin
                                phase_next = PH_WSTOP;
                                res.bus_op = OP_STOP;
                            end
                        end
                    end
                    PH_WSTOP: begin
                        poll_left_next = POLL_LIMIT;
                        phase_next     = PH_PSTART;
                        res_valid      = 1'b1;
                        res.bus_op     = OP_START;
                    end
                    PH_PSTART: begin
                        phase_next   = PH_PDEV;
                        res_valid    = 1'b1;
                        res.bus_op   = OP_WRITE;
                        res.bus_byte = device_byte_reg;
                    end
                    PH_PDEV: begin
                        res_valid = 1'b1;
                        if (item.ack) begin
                            if (bytes_left_reg != 16'd0) begin
                                chunk_left_next  = chunk_len(cfg.page_size_log2, cur_addr_reg,
                                                             bytes_left_reg);
                                device_byte_next = dev_byte_for(cfg, cur_addr_reg);
                                phase_next       = PH_START;
                                res.bus_op       = OP_START;
                            end else begin
                                phase_next = PH_FIN_OK;
                                res.bus_op = OP_STOP;
                            end
                        end else begin
                            poll_left_next = poll_dec;
                            if (poll_dec == 8'd0) begin
                                phase_next = PH_FIN_TO;
                                res.bus_op = OP_STOP;
                            end else begin
                                phase_next = PH_PSTART;
                                res.bus_op = OP_START;
                            end
                        end
                    end
                    PH_RSTART: begin
                        phase_next   = PH_RDEV;
                        res_valid    = 1'b1;
                        res.bus_op   = OP_WRITE;
                        res.bus_byte = device_byte_reg | 8'h01;
                    end
                    PH_RDEV: begin
                        if (!item.ack) begin
                            nack_abort = 1'b1;
                        end else begin
                            phase_next = PH_RDATA;
                            res_valid  = 1'b1;
                            res.bus_op = (bytes_left_reg > 16'd1) ? OP_READ_ACK
                                                                  : OP_READ_NACK;
                        end
                    end
                    PH_RDATA: begin
                        read_count_next = count_inc;
                        bytes_left_next = left_dec;
                        res_valid       = 1'b1;
                        res.read_valid  = 1'b1;
                        res.read_data   = item.rx_byte;
                        if (left_dec != 16'd0) begin
                            res.bus_op = (left_dec > 16'd1) ? OP_READ_ACK : OP_READ_NACK;
                        end else begin
                            phase_next = PH_FIN_OK;
                            res.bus_op = OP_STOP;
                        end
                    end
                    PH_FIN_OK, PH_FIN_NACK, PH_FIN_TO: begin
                        phase_next     = PH_IDLE;
                        res_valid      = 1'b1;
                        res.bus_op     = OP_DONE;
                        res.bytes_read = is_read_reg ? read_count_reg : 16'd0;
                        if (phase_reg == PH_FIN_NACK) begin
                            res.status = ST_NACK;
                        end else if (phase_reg == PH_FIN_TO) begin
                            res.status = ST_TIMEOUT;
                        end else begin
                            res.status = ST_OK;
                        end
                    end
                    default: begin
                        // idle or waiting for a data word: response dropped
                    end
                endcase
                if (nack_abort) begin
                    phase_next = PH_FIN_NACK;
                    res_valid  = 1'b1;
                    res.bus_op = OP_STOP;
                end
            end
            default: begin
            end
        endcase
    end

    // a page chunk never exceeds the largest page
    a_chunk_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        chunk_left_reg <= 7'd64)
        else $error("chunk count beyond page size");

    // while data words move, the chunk is live and fits in what is left
    a_chunk_live: assert property (@(posedge aclk) disable iff (!aresetn)
        (phase_reg == PH_DREQ || phase_reg == PH_WDATA) |->
            (chunk_left_reg != 7'd0 && {9'd0, chunk_left_reg} <= bytes_left_reg))
        else $error("data phase with empty chunk");

    // done always returns the sequencer to idle
    a_done_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        (step_valid && res_valid && res.bus_op == OP_DONE) |=> phase_reg == PH_IDLE)
        else $error("done without going idle");

    // a received byte is only reported while reading
    a_rx_in_read: assert property (@(posedge aclk) disable iff (!aresetn)
        (step_valid && res_valid && res.read_valid) |-> is_read_reg)
        else $error("read data outside a read transfer");

endmodule

FILE: dv/i2cee_seq_checker.sv
// ----------------------------------------------------------------------------
// i2cee_seq_checker
// Watches the request, command and register ports of the EEPROM sequencer,
// predicts every bus command word from the accepted request words and the
// current register settings, and compares the command words field by field.
// ----------------------------------------------------------------------------
module i2cee_seq_checker (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    input  logic        s_tready,
    input  logic [55:0] s_tdata,   // mem_addr, length, wr_data, ack, rx_byte, zero pad
    input  logic [1:0]  s_tuser,   // req_type
    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic [39:0] m_tdata,   // bus_byte, read_valid, read_data, status, bytes_read, pad
    input  logic [2:0]  m_tuser,   // bus_op
    input  logic        cfg_we,
    input  logic [1:0]  cfg_index,
    input  logic [2:0]  cfg_wdata,
    output int          mismatches,
    output int          pending
);
    import i2cee_pkg::*;

    // register copies
    logic [2:0]  ee_type;
    logic [2:0]  strap_pins;
    logic [2:0]  page_lg;

    // sequencer copy
    phase_t      ph;
    logic [15:0] cur;
    logic [15:0] bytes_todo;
    logic [6:0]  chunk;
    logic        lo_addr_due;
    logic [7:0]  polls;
    logic [7:0]  dsel;
    logic [15:0] rcnt;
    logic        rd_xfer;

    result_t     expected_cmds[$];
    int          n_bad = 0;

    assign mismatches = n_bad;

    function automatic logic [7:0] device_select(input logic [15:0] a);
        logic [2:0] sel;
        case (ee_type)
            EE_24C04: sel = {strap_pins[2:1], a[8]};
            EE_24C08: sel = {strap_pins[2], a[9:8]};
            EE_24C16: sel = a[10:8];
            default:  sel = strap_pins;
        endcase
        return {DEV_ID, sel, 1'b0};
    endfunction

    // bytes left before the page boundary, capped by what remains to write
    function automatic logic [6:0] page_room(input logic [15:0] a, input logic [15:0] n);
        int lg;
        int sz;
        int room;
        lg   = (page_lg > PAGE_LOG2_MAX) ? PAGE_LOG2_MAX : page_lg;
        sz   = 1 << lg;
        room = sz - int'(a & 16'(sz - 1));
        if (room > int'(n)) begin
            room = int'(n);
        end
        return 7'(room);
    endfunction

    task automatic advance_sequencer(input req_t rq, input logic [15:0] a,
                                     input logic [15:0] n, input logic [7:0] wd,
                                     input logic ak, input logic [7:0] rx);
        result_t r;
        bit      emit;
        bit      nacked;
        r      = '0;
        emit   = 1'b0;
        nacked = 1'b0;
        case (rq)
            REQ_BEGIN_WR, REQ_BEGIN_RD: begin
                if (ph == PH_IDLE) begin
                    emit        = 1'b1;
                    rd_xfer     = (rq == REQ_BEGIN_RD);
                    cur         = a;
                    bytes_todo  = n;
                    rcnt        = '0;
                    chunk       = '0;
                    lo_addr_due = 1'b0;
                    if (n == 16'd0) begin
                        r.bus_op = OP_DONE;
                        r.status = ST_OK;
                    end else begin
                        if (!rd_xfer) begin
                            chunk = page_room(a, n);
                        end
                        dsel     = device_select(a);
                        ph       = PH_START;
                        r.bus_op = OP_START;
                    end
                end
            end
            REQ_WR_DATA: begin
                if (ph == PH_DREQ) begin
                    emit       = 1'b1;
                    ph         = PH_WDATA;
                    r.bus_op   = OP_WRITE;
                    r.bus_byte = wd;
                end
            end
            default: begin
                emit = 1'b1;
                case (ph)
                    PH_START: begin
                        ph         = PH_DEV;
                        r.bus_op   = OP_WRITE;
                        r.bus_byte = dsel;
                    end
                    PH_DEV: begin
                        if (!ak) begin
                            nacked = 1'b1;
                        end else begin
                            ph          = PH_ADDR;
                            r.bus_op    = OP_WRITE;
                            lo_addr_due = (ee_type >= EE_24C32);
                            r.bus_byte  = lo_addr_due ? cur[15:8] : cur[7:0];
                        end
                    end
                    PH_ADDR: begin
                        if (!ak) begin
                            nacked = 1'b1;
                        end else if (lo_addr_due) begin
                            lo_addr_due = 1'b0;
                            r.bus_op    = OP_WRITE;
                            r.bus_byte  = cur[7:0];
                        end else if (rd_xfer) begin
                            ph       = PH_RSTART;
                            r.bus_op = OP_START;
                        end else begin
                            ph       = PH_DREQ;
                            r.bus_op = OP_REQ;
                        end
                    end
                    PH_WDATA: begin
                        if (!ak) begin
                            nacked = 1'b1;
                        end else begin
                            chunk      = chunk - 7'd1;
                            bytes_todo = bytes_todo - 16'd1;
                            cur        = cur + 16'd1;
                            if (chunk != 7'd0) begin
                                ph       = PH_DREQ;
                                r.bus_op = OP_REQ;
                            end else begin
                                ph       = PH_WSTOP;
                                r.bus_op = OP_STOP;
                            end
                        end
                    end
                    PH_WSTOP: begin
                        polls    = POLL_LIMIT;
                        ph       = PH_PSTART;
                        r.bus_op = OP_START;
                    end
                    PH_PSTART: begin
                        ph         = PH_PDEV;
                        r.bus_op   = OP_WRITE;
                        r.bus_byte = dsel;
                    end
                    PH_PDEV: begin
                        if (ak) begin
                            if (bytes_todo != 16'd0) begin
                                chunk    = page_room(cur, bytes_todo);
                                dsel     = device_select(cur);
                                ph       = PH_START;
                                r.bus_op = OP_START;
                            end else begin
                                ph       = PH_FIN_OK;
                                r.bus_op = OP_STOP;
                            end
                        end else begin
                            polls = polls - 8'd1;
                            if (polls == 8'd0) begin
                                ph       = PH_FIN_TO;
                                r.bus_op = OP_STOP;
                            end else begin
                                ph       = PH_PSTART;
                                r.bus_op = OP_START;
                            end
                        end
                    end
                    PH_RSTART: begin
                        ph         = PH_RDEV;
                        r.bus_op   = OP_WRITE;
                        r.bus_byte = {dsel[7:1], 1'b1};
                    end
                    PH_RDEV: begin
                        if (!ak) begin
                            nacked = 1'b1;
                        end else begin
                            ph       = PH_RDATA;
                            r.bus_op = (bytes_todo > 16'd1) ? OP_READ_ACK : OP_READ_NACK;
                        end
                    end
                    PH_RDATA: begin
                        rcnt       = rcnt + 16'd1;
                        bytes_todo = bytes_todo - 16'd1;
                        if (bytes_todo != 16'd0) begin
                            r.bus_op = (bytes_todo > 16'd1) ? OP_READ_ACK : OP_READ_NACK;
                        end else begin
                            ph       = PH_FIN_OK;
                            r.bus_op = OP_STOP;
                        end
                        r.read_valid = 1'b1;
                        r.read_data  = rx;
                    end
                    PH_FIN_OK, PH_FIN_NACK, PH_FIN_TO: begin
                        r.bus_op     = OP_DONE;
                        r.status     = (ph == PH_FIN_OK)   ? ST_OK :
                                       (ph == PH_FIN_NACK) ? ST_NACK : ST_TIMEOUT;
                        r.bytes_read = rd_xfer ? rcnt : 16'd0;
                        ph           = PH_IDLE;
                    end
                    default: begin
                        // idle or waiting for a data word: responses are dropped
                        emit = 1'b0;
                    end
                endcase
            end
        endcase
        if (nacked) begin
            ph       = PH_FIN_NACK;
            r.bus_op = OP_STOP;
        end
        if (emit) begin
            expected_cmds.push_back(r);
        end
    endtask

    task automatic check_field(input string fname, input int unsigned want,
                               input int unsigned got);
        if (want != got) begin
            $error("%s: expected %0d, got %0d", fname, want, got);
            n_bad++;
        end
    endtask

    always @(posedge aclk) begin
        result_t want;
        if (!aresetn) begin
            ee_type     = EE_24C01;
            strap_pins  = 3'd0;
            page_lg     = 3'd3;
            ph          = PH_IDLE;
            cur         = '0;
            bytes_todo  = '0;
            chunk       = '0;
            lo_addr_due = 1'b0;
            polls       = POLL_LIMIT;
            dsel        = {DEV_ID, 4'd0};
            rcnt        = '0;
            rd_xfer     = 1'b0;
            expected_cmds.delete();
        end else begin
            if (m_tvalid && m_tready) begin
                if (expected_cmds.size() == 0) begin
                    $error("command word with none expected: bus_op %0d", m_tuser);
                    n_bad++;
                end else begin
                    want = expected_cmds.pop_front();
                    check_field("bus_op",     want.bus_op,     m_tuser);
                    check_field("bus_byte",   want.bus_byte,   m_tdata[7:0]);
                    check_field("read_valid", want.read_valid, m_tdata[8]);
                    check_field("read_data",  want.read_data,  m_tdata[16:9]);
                    check_field("status",     want.status,     m_tdata[18:17]);
                    check_field("bytes_read", want.bytes_read, m_tdata[34:19]);
                end
            end
            if (s_tvalid && s_tready) begin
                advance_sequencer(req_t'(s_tuser), s_tdata[15:0], s_tdata[31:16],
                                  s_tdata[39:32], s_tdata[40], s_tdata[48:41]);
            end
            if (cfg_we) begin
                case (cfg_index)
                    CFG_PART_TYPE: ee_type    = cfg_wdata;
                    CFG_CHIP_PINS: strap_pins = cfg_wdata;
                    CFG_PAGE_LOG2: page_lg    = cfg_wdata;
                    default: ;
                endcase
            end
        end
        pending <= expected_cmds.size();
    end

endmodule

FILE: dv/i2c_eeprom_access_sequencer_tb.sv
// ----------------------------------------------------------------------------
// i2c_eeprom_access_sequencer_tb
// Plays both the host and the byte-level I2C engine around the sequencer:
// starts reads and writes, answers every bus command (acks, nacks, poll
// retries, received bytes, data bytes) and mixes in words the block must drop.
// Runs directed transfers first, then random ones over random register
// settings, with random stalls on both channels. A checker compares output.
// ----------------------------------------------------------------------------
module i2c_eeprom_access_sequencer_tb;
    import i2cee_pkg::*;

    localparam int ITEMS          = 1700;
    localparam int WATCHDOG_LIMIT = 2000;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [55:0] s_tdata = '0;     // mem_addr, length, wr_data, ack, rx_byte, zero pad
    logic [1:0]  s_tuser = REQ_BEGIN_WR;  // req_type
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [39:0] m_tdata;          // bus_byte, read_valid, read_data, status, bytes_read, pad
    logic [2:0]  m_tuser;          // bus_op
    logic        cfg_we = 1'b0;
    logic [1:0]  cfg_index = CFG_PART_TYPE;
    logic [2:0]  cfg_wdata = '0;

    int          mismatches;
    int          pending;

    int          s_words = 0;
    int          items_sent = 0;
    int          stuck_cycles = 0;
    op_t         seen_ops[$];
    bit          calm = 1'b0;
    int          mode_left = 0;
    int          stall_left = 0;

    always begin
        #6 aclk = 1'b1;
        #6 aclk = 1'b0;
    end

    i2c_eeprom_access_sequencer dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    i2cee_seq_checker chk (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tuser    (s_tuser),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .m_tuser    (m_tuser),
        .cfg_we     (cfg_we),
        .cfg_index  (cfg_index),
        .cfg_wdata  (cfg_wdata),
        .mismatches (mismatches),
        .pending    (pending)
    );

    // mostly short gaps, a few long ones
    function automatic int pick_gap();
        int r;
        r = $urandom_range(99);
        if (r < 60) return 0;
        if (r < 95) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    always @(posedge aclk) begin
        if (aresetn && s_tvalid && s_tready) begin
            s_words <= s_words + 1;
        end
        if (aresetn && m_tvalid && m_tready) begin
            seen_ops.push_back(op_t'(m_tuser));
        end
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || cfg_we) begin
            stuck_cycles <= 0;
        end else begin
            stuck_cycles <= stuck_cycles + 1;
        end
        if (stuck_cycles == WATCHDOG_LIMIT) begin
            $display("TB_ERROR");
            $finish;
        end
    end

    // command side back-pressure, with calm stretches that start no new stalls
    always @(negedge aclk) begin
        int g;
        if (mode_left == 0) begin
            calm      <= ($urandom_range(3) == 0);
            mode_left <= $urandom_range(50, 300);
        end else begin
            mode_left <= mode_left - 1;
        end
        if (stall_left > 0) begin
            m_tready   <= 1'b0;
            stall_left <= stall_left - 1;
        end else if (calm) begin
            m_tready <= 1'b1;
        end else begin
            g = pick_gap();
            m_tready   <= (g == 0);
            stall_left <= (g > 0) ? g - 1 : 0;
        end
    end

    task automatic send_word(input req_t rq, input logic [15:0] a, input logic [15:0] n,
                             input logic [7:0] wd, input logic ak, input logic [7:0] rx,
                             input bit counted);
        int gap;
        int mark;
        gap = calm ? 0 : pick_gap();
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= rq;
        s_tdata  <= {7'd0, rx, ak, wd, n, a};
        mark = s_words;
        do @(negedge aclk); while (s_words == mark);
        if (counted) begin
            items_sent++;
        end
    endtask

    task automatic send_noise(input req_t rq);
        send_word(rq, 16'($urandom), 16'($urandom), 8'($urandom), 1'($urandom),
                  8'($urandom), 1'b0);
    endtask

    // valid stays up only if another word follows in this same step
    task automatic next_op(output op_t op);
        if (seen_ops.size() == 0) begin
            s_tvalid <= 1'b0;
            while (seen_ops.size() == 0) @(negedge aclk);
        end
        op = seen_ops.pop_front();
    endtask

    // one transfer, answering commands until done
    // nack_at: which non-poll write byte gets a nack (0 none)
    // poll_naks: nacked polls per chunk before the device answers
    task automatic run_xfer(input bit rd, input logic [15:0] addr, input logic [15:0] len,
                            input int nack_pct, input int nack_at, input int poll_naks);
        op_t  op;
        int   wr_seen;
        int   poll_cnt;
        bit   polling;
        logic ak;
        wr_seen  = 0;
        poll_cnt = 0;
        polling  = 1'b0;
        if ($urandom_range(5) == 0) begin
            send_noise($urandom_range(1) ? REQ_RESPONSE : REQ_WR_DATA);
        end
        send_word(rd ? REQ_BEGIN_RD : REQ_BEGIN_WR, addr, len, 8'($urandom),
                  1'($urandom), 8'($urandom), 1'b1);
        forever begin
            next_op(op);
            if (op == OP_DONE) break;
            ak = 1'($urandom);
            if (op == OP_WRITE) begin
                if (polling) begin
                    ak = (poll_cnt >= poll_naks);
                    if (ak) begin
                        polling  = 1'b0;
                        poll_cnt = 0;
                    end else begin
                        poll_cnt++;
                    end
                end else begin
                    wr_seen++;
                    ak = !(wr_seen == nack_at || $urandom_range(99) < nack_pct);
                end
            end else if (op == OP_STOP && !rd) begin
                polling = 1'b1;
            end
            // a wrong-kind word first, which the block has to drop
            if ($urandom_range(7) == 0) begin
                if ($urandom_range(2) == 0) begin
                    send_noise($urandom_range(1) ? REQ_BEGIN_RD : REQ_BEGIN_WR);
                end else begin
                    send_noise((op == OP_REQ) ? REQ_RESPONSE : REQ_WR_DATA);
                end
            end
            if (op == OP_REQ) begin
                send_word(REQ_WR_DATA, 16'($urandom), 16'($urandom), 8'($urandom),
                          1'($urandom), 8'($urandom), 1'b1);
            end else begin
                send_word(REQ_RESPONSE, 16'($urandom), 16'($urandom), 8'($urandom),
                          ak, 8'($urandom), 1'b1);
            end
            // still busy unless that was a stop: begin words get dropped
            if (op != OP_STOP && $urandom_range(9) == 0) begin
                repeat ($urandom_range(1, 3)) begin
                    send_noise($urandom_range(1) ? REQ_BEGIN_RD : REQ_BEGIN_WR);
                end
            end
        end
        s_tvalid <= 1'b0;
        @(negedge aclk);
    endtask

    task automatic random_xfer();
        int          sel;
        logic [15:0] a;
        logic [15:0] n;
        int          npct;
        int          pnaks;
        sel = $urandom_range(99);
        if (sel < 5) begin
            n = 16'd0;
        end else if (sel < 75) begin
            n = 16'($urandom_range(1, 8));
        end else if (sel < 97) begin
            n = 16'($urandom_range(9, 70));
        end else begin
            n = 16'($urandom_range(71, 200));
        end
        a = 16'($urandom);
        if ($urandom_range(7) == 0) begin
            a = 16'hFFFF - 16'($urandom_range(0, 5));
        end
        npct  = ($urandom_range(3) == 0) ? $urandom_range(3, 12) : 0;
        pnaks = ($urandom_range(149) == 0) ? 300 : $urandom_range(0, 3);
        run_xfer(1'($urandom_range(1)), a, n, npct, 0, pnaks);
    endtask

    task automatic program_regs(input logic [2:0] t, input logic [2:0] p,
                                input logic [2:0] lg);
        while (pending != 0) @(negedge aclk);
        repeat (6) @(negedge aclk);
        cfg_we    <= 1'b1;
        cfg_index <= CFG_PART_TYPE;
        cfg_wdata <= t;
        @(negedge aclk);
        cfg_index <= CFG_CHIP_PINS;
        cfg_wdata <= p;
        @(negedge aclk);
        cfg_index <= CFG_PAGE_LOG2;
        cfg_wdata <= lg;
        @(negedge aclk);
        cfg_we <= 1'b0;
    endtask

    initial begin
        repeat (4) @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        program_regs(EE_24C01, 3'd0, 3'd3);
        // stray response and data word while idle
        send_noise(REQ_RESPONSE);
        send_noise(REQ_WR_DATA);
        run_xfer(1'b0, 16'h0010, 16'd0, 0, 0, 0);
        run_xfer(1'b1, 16'h0010, 16'd0, 0, 0, 0);
        run_xfer(1'b0, 16'h0006, 16'd5, 0, 0, 1);
        run_xfer(1'b1, 16'hFFFE, 16'd4, 0, 0, 0);
        run_xfer(1'b1, 16'h0020, 16'd1, 0, 0, 0);
        run_xfer(1'b0, 16'hFFFE, 16'd4, 0, 0, 0);
        run_xfer(1'b0, 16'h1234, 16'hFFFF, 0, 2, 0);
        run_xfer(1'b1, 16'h1234, 16'hFFFF, 0, 1, 0);
        run_xfer(1'b1, 16'h0100, 16'd3, 0, 3, 0);
        run_xfer(1'b0, 16'h0200, 16'd4, 0, 3, 0);
        // device never answers the write poll
        run_xfer(1'b0, 16'h0040, 16'd2, 0, 0, 300);

        program_regs(EE_24C32, 3'd7, 3'd0);
        run_xfer(1'b0, 16'hABCD, 16'd3, 0, 0, 0);
        run_xfer(1'b1, 16'hFFFF, 16'd2, 0, 0, 0);
        program_regs(EE_24C16, 3'd5, 3'd7);
        run_xfer(1'b0, 16'h07F0, 16'd70, 0, 0, 0);
        program_regs(3'd7, 3'd7, 3'd6);
        run_xfer(1'b0, 16'h8001, 16'd6, 0, 0, 2);
        program_regs(EE_24C04, 3'd6, 3'd4);
        run_xfer(1'b0, 16'h01F8, 16'd20, 0, 0, 0);
        program_regs(EE_24C08, 3'd4, 3'd5);
        run_xfer(1'b1, 16'h03FF, 16'd3, 0, 0, 0);

        // random transfers fill up the total word count
        while (items_sent < ITEMS) begin
            program_regs(3'($urandom), 3'($urandom), 3'($urandom));
            repeat ($urandom_range(8, 20)) begin
                if (items_sent < ITEMS) begin
                    random_xfer();
                end
            end
        end

        while (pending != 0) @(negedge aclk);
        repeat (20) @(negedge aclk);
        if (mismatches == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule

FILE: files.f
hw/rtl/i2cee_pkg.sv
hw/rtl/i2cee_seq.sv
hw/rtl/i2c_eeprom_access_sequencer.sv
dv/i2cee_seq_checker.sv
dv/i2c_eeprom_access_sequencer_tb.sv
